/* src/lidar_frame_sync_parser_defines.svh */
// Assertion macros used by the frame parser module lfsp_back.
// No dependencies; the enclosing module must provide i_clk and i_rst_n.
`ifndef LIDAR_FRAME_SYNC_PARSER_DEFINES_SVH
`define LIDAR_FRAME_SYNC_PARSER_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define LFSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LFSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/lfsp_pkg.sv */
// Shared types and constants for the range-sensor frame parser.
// No dependencies.
package lfsp_pkg;

    localparam int FRAME_LEN_DEF = 9;
    localparam logic [7:0] HEADER_BYTE = 8'h59;
    localparam int QUEUE_DEPTH = 2;
    localparam int MIN_HEADERS = 2;

    typedef enum logic {
        ST_HUNT,
        ST_SYNC
    } t_state;

    // One classified byte on its way from the front to the parser.
    typedef struct packed {
        logic       is_hdr;
        logic [7:0] data;
    } t_item;

endpackage

/* src/lfsp_front.sv */
// Input side: holds the enable register, takes bytes and tags header bytes.
// Depends on lfsp_pkg.
module lfsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,      // [7:0] rx_byte
    input  logic           i_queue_full,
    output logic           o_push,
    output lfsp_pkg::t_item o_item
);
    import lfsp_pkg::*;

    logic r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !i_queue_full;

    // Drop bytes while disabled: the transfer completes but nothing is queued.
    assign o_push        = s_axis_tvalid && s_axis_tready && r_enable;
    assign o_item.data   = s_axis_tdata;
    assign o_item.is_hdr = (s_axis_tdata == HEADER_BYTE);

endmodule

/* src/lfsp_queue.sv */
// Short queue of classified bytes between the front and the parser.
// Depends on lfsp_pkg.
module lfsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lfsp_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lfsp_pkg::t_item o_item
);
    import lfsp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/lfsp_back.sv */
// Frame parser: header hunt, frame collection, running checksum and the
// output register. Depends on lfsp_pkg and lidar_frame_sync_parser_defines.svh.
`include "lidar_frame_sync_parser_defines.svh"

module lfsp_back #(
    parameter int FRAME_LEN = lfsp_pkg::FRAME_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lfsp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata      // [15:0] distance_cm
);
    import lfsp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] POS_FULL = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] POS_MAXH = CNT_W'(FRAME_LEN - 2);
    localparam logic [CNT_W-1:0] POS_MINH = CNT_W'(MIN_HEADERS);
    localparam logic [CNT_W-1:0] POS_LO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_HI   = CNT_W'(3);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_lo, n_lo;
    logic [7:0]       r_hi, n_hi;
    logic             r_out_valid;
    logic [15:0]      r_out_data;
    logic             emit;
    logic             store;

    // Take a byte whenever the result slot is free or being drained.
    assign o_pop = i_valid && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_lo    = r_lo;
        n_hi    = r_hi;
        emit    = 1'b0;
        store   = 1'b0;
        if (o_pop) begin
            case (r_state)
                ST_HUNT: begin
                    if (i_item.is_hdr) begin
                        if (r_pos < POS_FULL) begin
                            store = 1'b1;
                            n_pos = r_pos + 1'b1;
                        end else begin
                            // Too many headers in a row: start counting again.
                            n_pos = '0;
                        end
                    end else if (r_pos >= POS_MINH && r_pos <= POS_MAXH) begin
                        store   = 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_state = ST_SYNC;
                    end else begin
                        n_pos = '0;
                    end
                end
                ST_SYNC: begin
                    if (r_pos == POS_LAST) begin
                        emit    = (r_sum == i_item.data);
                        n_pos   = '0;
                        n_state = ST_HUNT;
                    end else begin
                        store = 1'b1;
                        n_pos = r_pos + 1'b1;
                    end
                end
                default: begin
                    n_pos   = '0;
                    n_state = ST_HUNT;
                end
            endcase
            // Accumulate the checksum and keep the two distance bytes.
            if (store) begin
                n_sum = (r_pos == '0) ? i_item.data : r_sum + i_item.data;
                if (r_pos == POS_LO) begin
                    n_lo = i_item.data;
                end
                if (r_pos == POS_HI) begin
                    n_hi = i_item.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {r_hi, r_lo};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `LFSP_ASSERT_IMPLY(a_sync_pos, r_state == ST_SYNC,
        r_pos >= (POS_MINH + 1'b1) && r_pos <= POS_LAST, "sync position out of range")
    `LFSP_ASSERT_ALWAYS(a_hunt_pos, r_state != ST_HUNT || r_pos <= POS_FULL,
        "header count past frame length")
    `LFSP_ASSERT_IMPLY(a_emit_slot, emit,
        r_state == ST_SYNC && (!r_out_valid || m_axis_tready), "result would overwrite")

endmodule

/* src/lidar_frame_sync_parser.sv */
// Range-sensor frame parser: one received byte per transfer in, one distance
// per good frame out; the header hunt counts the header bytes in a row.
// Processes one byte per cycle while the output is not stalled. A byte passes
// the front and is written into the two-entry queue, from which the parser
// takes it; the distance of a good frame enters the output register when the
// parser takes its checksum byte. The sustained rate is set by the parser,
// which retires one queued byte per cycle while its result register is free
// or draining. With enable at 0 bytes are accepted and discarded. Frame
// checksum is the 8-bit wrapping sum of all bytes but the last; frames that
// fail it produce nothing, and the parser always returns to header hunt.
// Depends on lfsp_pkg, lfsp_front, lfsp_queue and lfsp_back.
module lidar_frame_sync_parser #(
    parameter int FRAME_LEN = lfsp_pkg::FRAME_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,      // enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata      // [15:0] distance_cm
);
    import lfsp_pkg::*;

    logic  q_full;
    logic  push;
    t_item front_item;
    logic  q_valid;
    logic  pop;
    t_item q_item;

    lfsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_queue_full  (q_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    lfsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lfsp_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_item        (q_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* dv/tb_lidar_frame_sync_parser.sv */
// Self-checking testbench for lidar_frame_sync_parser: byte stream in, distances out.
// Tracks header hunt, frame collection and checksum in its own model of the parser.
// Depends on lfsp_pkg and the parser RTL.
module tb_lidar_frame_sync_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsp_pkg::*;

    localparam int FRAME_LEN    = FRAME_LEN_DEF;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] distance_cm

    lidar_frame_sync_parser #(
        .FRAME_LEN(FRAME_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Parser model state
    logic        parse_en;
    t_state      parse_state;
    logic [4:0]  hdr_cnt;
    logic [4:0]  byte_pos;
    logic [7:0]  frame_mem [FRAME_LEN];

    logic [7:0]  rx_pending [$];
    logic [7:0]  frame_buf [$];
    logic [15:0] distance_fifo [$];

    logic        idle_on  = 1'b1;
    logic        hold_src = 1'b0;
    int          src_gap  = 0;
    int          sink_gap = 0;
    int          bytes_queued = 0;
    int          bytes_sent   = 0;
    int          dist_checked = 0;
    int          frames_bad   = 0;
    int          fail_cnt     = 0;
    int          cycle_cnt    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic track_frame_byte(input logic [7:0] b);
        logic [7:0] sum;
        sum = 8'h00;
        if (!parse_en) begin
            return;
        end
        if (parse_state == ST_SYNC) begin
            if (byte_pos < FRAME_LEN) begin
                frame_mem[byte_pos] = b;
            end
            byte_pos++;
            if (byte_pos >= FRAME_LEN) begin
                for (int i = 0; i < FRAME_LEN - 1; i++) begin
                    sum += frame_mem[i];
                end
                if (sum == frame_mem[FRAME_LEN-1]) begin
                    distance_fifo.push_back({frame_mem[3], frame_mem[2]});
                end else begin
                    frames_bad++;
                end
                parse_state = ST_HUNT;
                hdr_cnt     = '0;
                byte_pos    = '0;
            end
        end else if (b == HEADER_BYTE) begin
            if (hdr_cnt < FRAME_LEN) begin
                frame_mem[hdr_cnt] = b;
                hdr_cnt++;
            end else begin
                // overlong header run: restart the count, byte not counted
                hdr_cnt  = '0;
                byte_pos = '0;
            end
        end else if (hdr_cnt >= MIN_HEADERS && hdr_cnt <= FRAME_LEN - 2) begin
            frame_mem[hdr_cnt] = b;
            hdr_cnt++;
            parse_state = ST_SYNC;
            byte_pos    = hdr_cnt;
        end else begin
            hdr_cnt = '0;
        end
    endtask

    // Driver: advance to the next byte once the current transfer completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_frame_byte(s_axis_tdata);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (hold_src || rx_pending.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 8);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata  <= rx_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each distance transfer, stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (distance_fifo.size() == 0) begin
                $error("distance_cm: unexpected result, expected none, actual %0d",
                       m_axis_tdata);
                fail_cnt++;
            end else begin
                if (m_axis_tdata !== distance_fifo[0]) begin
                    $error("distance_cm mismatch: expected %0d, actual %0d",
                           distance_fifo[0], m_axis_tdata);
                    fail_cnt++;
                end
                void'(distance_fifo.pop_front());
                dist_checked++;
            end
        end
        if (sink_gap != 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d distances still pending",
                     cycle_cnt, distance_fifo.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        bytes_queued++;
    endtask

    // Build one frame into frame_buf; lo/hi land on bytes 2/3 when not headers
    task automatic build_frame(input int n_hdr, input bit bad,
                               input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] sum;
        sum = 8'h00;
        frame_buf.delete();
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            frame_buf.push_back(i < n_hdr ? HEADER_BYTE : 8'($urandom));
        end
        if (n_hdr <= 2) frame_buf[2] = lo;
        if (n_hdr <= 3) frame_buf[3] = hi;
        if (frame_buf[n_hdr] == HEADER_BYTE) frame_buf[n_hdr] = ~HEADER_BYTE;
        foreach (frame_buf[i]) sum += frame_buf[i];
        if (bad) sum += 8'($urandom_range(1, 255));
        frame_buf.push_back(sum);
    endtask

    task automatic push_frame_buf(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            push_byte(frame_buf[i]);
        end
    endtask

    task automatic gen_random_bytes(input int n_items);
        int base;
        int pick;
        int k;
        base = bytes_queued;
        while (bytes_queued - base < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                build_frame($urandom_range(MIN_HEADERS, FRAME_LEN - 2),
                            $urandom_range(0, 6) == 0, 8'($urandom), 8'($urandom));
                push_frame_buf(FRAME_LEN);
            end else if (pick < 75) begin
                // header run at or past the limit, then a frame
                k = $urandom_range(FRAME_LEN - 1, FRAME_LEN + 1);
                repeat (k) push_byte(HEADER_BYTE);
                build_frame($urandom_range(MIN_HEADERS, FRAME_LEN - 2), 1'b0,
                            8'($urandom), 8'($urandom));
                push_frame_buf(FRAME_LEN);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    push_byte($urandom_range(0, 1) ? HEADER_BYTE : 8'($urandom));
                end
            end else if (pick < 93) begin
                build_frame($urandom_range(MIN_HEADERS, FRAME_LEN - 2), 1'b0,
                            8'($urandom), 8'($urandom));
                push_frame_buf($urandom_range(1, FRAME_LEN - 1));
            end else begin
                // lone header, dropped on the next non-header
                push_byte(HEADER_BYTE);
                push_byte(~HEADER_BYTE);
                build_frame($urandom_range(MIN_HEADERS, FRAME_LEN - 2), 1'b0,
                            8'($urandom), 8'($urandom));
                push_frame_buf(FRAME_LEN);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_pending.size() != 0 || s_axis_tvalid || distance_fifo.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic en);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        parse_en = en;
    endtask

    initial begin
        parse_en    = 1'b0;
        parse_state = ST_HUNT;
        hdr_cnt     = '0;
        byte_pos    = '0;
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Enable is low out of reset: a good frame must be dropped
        build_frame(MIN_HEADERS, 1'b0, 8'h34, 8'h12);
        push_frame_buf(FRAME_LEN);
        wait_idle();

        write_enable(1'b1);
        build_frame(MIN_HEADERS, 1'b0, 8'hFF, 8'hFF);
        push_frame_buf(FRAME_LEN);
        build_frame(MIN_HEADERS, 1'b1, 8'h00, 8'h00);
        push_frame_buf(FRAME_LEN);
        push_byte(HEADER_BYTE);
        push_byte(8'hA5);
        wait_idle();

        gen_random_bytes(700);
        // Hold the source once until every distance has drained
        while (rx_pending.size() > 350) @(posedge i_clk);
        hold_src <= 1'b1;
        do @(posedge i_clk);
        while (s_axis_tvalid || distance_fifo.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        hold_src <= 1'b0;
        wait_idle();

        // Split a zero-distance frame around a disabled window
        build_frame(MIN_HEADERS, 1'b0, 8'h00, 8'h00);
        push_frame_buf(5);
        wait_idle();
        write_enable(1'b0);
        repeat (30) push_byte($urandom_range(0, 1) ? HEADER_BYTE : 8'($urandom));
        wait_idle();
        write_enable(1'b1);
        for (int i = 5; i < FRAME_LEN; i++) push_byte(frame_buf[i]);
        wait_idle();

        gen_random_bytes(700);
        wait_idle();

        idle_on <= 1'b0;
        gen_random_bytes(350);
        wait_idle();

        $display("Sent %0d bytes over enable on/off phases; checked %0d distances,",
                 bytes_sent, dist_checked);
        $display("saw %0d frames with a bad checksum, %0d mismatches", frames_bad, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lfsp_pkg.sv
src/lfsp_front.sv
src/lfsp_queue.sv
src/lfsp_back.sv
src/lidar_frame_sync_parser.sv
dv/tb_lidar_frame_sync_parser.sv
